### rtl/core/atan2oct_pkg.sv
// Shared types and fixed field widths for the table-based atan2 unit.
`default_nettype none

package atan2oct_pkg;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 13;

    // Octant and special-case flags that ride alongside each beat.
    typedef struct packed {
        logic valid;
        logic both_zero;
        logic x_zero;
        logic y_pos;
        logic x_neg;
        logic ax_gt_ay;
    } t_ctl;

endpackage

`default_nettype wire

### rtl/core/atan2_octant_lut_unit.sv
// Pipelined four-quadrant arctangent: magnitude divide, table lookup, octant fold.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start / busy       | i_y_coord, i_x_coord (s32, FRAC_BITS frac)
//  result   | o_strobe (1 cycle) | o_angle (s13, FRAC_BITS frac, radians)
//
// One beat is taken every cycle while busy is low; a beat passes the magnitude, order,
// restoring divider (one quotient bit per stage), index, table and output registers.
// Reset is synchronous and active low; busy is high during reset and the cycle after.
// The result side cannot stall, so the pipeline advances every cycle and never holds.
`default_nettype none

module atan2_octant_lut_unit #(
    parameter int LUT_ENTRIES = 256,
    parameter int FRAC_BITS   = 10
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [atan2oct_pkg::COORD_W-1:0] i_y_coord,
    input  wire logic signed [atan2oct_pkg::COORD_W-1:0] i_x_coord,
    output logic                                        o_strobe,
    output logic signed [atan2oct_pkg::ANGLE_W-1:0]      o_angle
);

    localparam int CW      = atan2oct_pkg::COORD_W;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int IDX_W   = $clog2(LUT_ENTRIES);
    localparam int PROD_W  = IDX_W + Q_W;
    localparam int SH_W    = PROD_W - FRAC_BITS;
    localparam int ANG_W   = FRAC_BITS + 3;
    localparam int PI_VAL  = $rtoi(3.141592653589793 * (2.0 ** FRAC_BITS));
    localparam int PI2_VAL = PI_VAL / 2;

    // ---------------- stage 0: magnitudes ----------------
    logic          r_busy;
    logic          r_v0;
    logic          r_yneg0;
    logic          r_xneg0;
    logic [CW-1:0] r_ay0;
    logic [CW-1:0] r_ax0;
    logic [CW-1:0] n_ay0;
    logic [CW-1:0] n_ax0;

    assign busy  = r_busy;
    assign n_ay0 = i_y_coord[CW-1] ? (~i_y_coord + CW'(1)) : i_y_coord;
    assign n_ax0 = i_x_coord[CW-1] ? (~i_x_coord + CW'(1)) : i_x_coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_v0   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_v0   <= start && !r_busy;
        end
        r_yneg0 <= i_y_coord[CW-1];
        r_xneg0 <= i_x_coord[CW-1];
        r_ay0   <= n_ay0;
        r_ax0   <= n_ax0;
    end

    // ---------------- stage 1: order and classify ----------------
    atan2oct_pkg::t_ctl r_ctl1;
    atan2oct_pkg::t_ctl n_ctl1;
    logic [CW-1:0]      r_min1;
    logic [CW-1:0]      r_max1;

    always_comb begin
        n_ctl1.valid     = r_v0;
        n_ctl1.both_zero = (r_ax0 == '0) && (r_ay0 == '0);
        n_ctl1.x_zero    = (r_ax0 == '0);
        n_ctl1.y_pos     = !r_yneg0 && (r_ay0 != '0);
        n_ctl1.x_neg     = r_xneg0;
        n_ctl1.ax_gt_ay  = r_ax0 > r_ay0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= n_ctl1;
        end
        r_min1 <= n_ctl1.ax_gt_ay ? r_ay0 : r_ax0;
        r_max1 <= n_ctl1.ax_gt_ay ? r_ax0 : r_ay0;
    end

    // ---------------- divide: one quotient bit per stage, MSB first ----------------
    atan2oct_pkg::t_ctl r_ctl_d [FRAC_BITS+1];
    logic [CW-1:0]      r_rem   [FRAC_BITS+1];
    logic [CW-1:0]      r_dvs   [FRAC_BITS+1];
    logic [Q_W-1:0]     r_q     [FRAC_BITS+1];

    for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_div
        atan2oct_pkg::t_ctl w_ctl_in;
        logic [CW-1:0]      w_rem_in;
        logic [CW-1:0]      w_dvs_in;
        logic [Q_W-1:0]     w_q_in;
        logic [CW:0]        w_trial;
        logic               w_ge;

        if (j == 0) begin : g_first
            assign w_ctl_in = r_ctl1;
            assign w_rem_in = r_min1;
            assign w_dvs_in = r_max1;
            assign w_q_in   = '0;
            assign w_trial  = {1'b0, w_rem_in};
        end else begin : g_next
            assign w_ctl_in = r_ctl_d[j-1];
            assign w_rem_in = r_rem[j-1];
            assign w_dvs_in = r_dvs[j-1];
            assign w_q_in   = r_q[j-1];
            assign w_trial  = {w_rem_in, 1'b0};
        end

        assign w_ge = w_trial >= {1'b0, w_dvs_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl_d[j] <= '0;
            end else begin
                r_ctl_d[j] <= w_ctl_in;
            end
            r_rem[j] <= w_ge ? CW'(w_trial - {1'b0, w_dvs_in}) : CW'(w_trial);
            r_dvs[j] <= w_dvs_in;
            r_q[j]   <= {w_q_in[Q_W-2:0], w_ge};
        end
    end

    // ---------------- index: scale ratio to table range ----------------
    atan2oct_pkg::t_ctl r_ctl_i;
    logic [IDX_W-1:0]   r_idx;
    logic [PROD_W-1:0]  w_prod;
    logic [SH_W-1:0]    w_sh;

    assign w_prod = PROD_W'(r_q[FRAC_BITS]) * PROD_W'(LUT_ENTRIES - 1);
    assign w_sh   = SH_W'(w_prod >> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_i <= '0;
        end else begin
            r_ctl_i <= r_ctl_d[FRAC_BITS];
        end
        if (w_sh > SH_W'(LUT_ENTRIES - 1)) begin
            r_idx <= IDX_W'(LUT_ENTRIES - 1);
        end else begin
            r_idx <= w_sh[IDX_W-1:0];
        end
    end

    // ---------------- table read: atan(i/(N-1)) scaled, truncated ----------------
    logic [FRAC_BITS-1:0] w_rom [LUT_ENTRIES];

    for (genvar g = 0; g < LUT_ENTRIES; g++) begin : g_rom
        localparam int ROM_VAL =
            $rtoi($atan(real'(g) / real'(LUT_ENTRIES - 1)) * (2.0 ** FRAC_BITS));
        assign w_rom[g] = FRAC_BITS'(ROM_VAL);
    end

    atan2oct_pkg::t_ctl   r_ctl_r;
    logic [FRAC_BITS-1:0] r_lut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_r <= '0;
        end else begin
            r_ctl_r <= r_ctl_i;
        end
        r_lut <= w_rom[r_idx];
    end

    // ---------------- fold into the right octant ----------------
    logic signed [ANG_W-1:0]                   w_lut;
    logic signed [ANG_W-1:0]                   w_pi;
    logic signed [ANG_W-1:0]                   w_pi2;
    logic signed [ANG_W-1:0]                   n_val;
    logic signed [CW-1:0]                      w_wide;
    logic                                      r_strobe;
    logic signed [atan2oct_pkg::ANGLE_W-1:0]   r_angle;

    assign w_lut = signed'({3'b000, r_lut});
    assign w_pi  = ANG_W'(PI_VAL);
    assign w_pi2 = ANG_W'(PI2_VAL);

    always_comb begin
        if (r_ctl_r.both_zero) begin
            n_val = '0;
        end else if (r_ctl_r.x_zero) begin
            n_val = r_ctl_r.y_pos ? w_pi2 : -w_pi2;
        end else if (r_ctl_r.y_pos) begin
            n_val = r_ctl_r.ax_gt_ay ? w_lut : (w_pi2 - w_lut);
            if (r_ctl_r.x_neg) begin
                n_val = w_pi - n_val;
            end
        end else begin
            // zero y lands here as well
            n_val = r_ctl_r.ax_gt_ay ? -w_lut : (w_lut - w_pi2);
            if (r_ctl_r.x_neg) begin
                n_val = -w_pi - n_val;
            end
        end
    end

    assign w_wide = CW'(n_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_ctl_r.valid;
        end
        r_angle <= w_wide[atan2oct_pkg::ANGLE_W-1:0];
    end

    assign o_strobe = r_strobe;
    assign o_angle  = r_angle;

endmodule

`default_nettype wire

### verif/atan2_angle_checker.sv
// Checker for the atan2 unit: predicts each angle beat and compares it with the result stream.
module atan2_angle_checker (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    start,
    input  wire logic                                    busy,
    input  wire logic signed [atan2oct_pkg::COORD_W-1:0] i_y_coord,
    input  wire logic signed [atan2oct_pkg::COORD_W-1:0] i_x_coord,
    input  wire logic                                    o_strobe,
    input  wire logic signed [atan2oct_pkg::ANGLE_W-1:0] o_angle,
    output int                                           fail_count,
    output int                                           pending
);

    localparam int COORD_W     = atan2oct_pkg::COORD_W;
    localparam int ANGLE_W     = atan2oct_pkg::ANGLE_W;
    localparam int TABLE_SIZE  = 256;
    localparam int FRAC        = 10;
    localparam int PI_FIX      = 3216;
    localparam int HALF_PI_FIX = 1608;

    typedef struct {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic signed [ANGLE_W-1:0] angle;
    } t_angle_rec;

    t_angle_rec angle_q[$];
    int         arctan_rom[TABLE_SIZE];

    // Entry i holds atan(i / (TABLE_SIZE-1)) in fixed point, truncated.
    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            arctan_rom[i] = $rtoi($atan(real'(i) / real'(TABLE_SIZE - 1)) * real'(1 << FRAC));
        end
    end

    function automatic int table_angle(input logic [32:0] num, input logic [32:0] den);
        logic [63:0] ratio;
        logic [63:0] idx;
        ratio = ({31'd0, num} << FRAC) / {31'd0, den};
        idx   = (64'(TABLE_SIZE - 1) * ratio) >> FRAC;
        if (idx > 64'(TABLE_SIZE - 1)) idx = 64'(TABLE_SIZE - 1);
        return arctan_rom[int'(idx)];
    endfunction

    function automatic logic signed [ANGLE_W-1:0] predict_angle(
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] x
    );
        logic              y_neg;
        logic              x_neg;
        logic [32:0]       mag_y;
        logic [32:0]       mag_x;
        logic signed [31:0] val;
        y_neg = y[COORD_W-1];
        x_neg = x[COORD_W-1];
        // Magnitude of the most negative value is exactly 2^31 in 33 bits.
        mag_y = y_neg ? (33'h1_0000_0000 - {1'b0, y}) : {1'b0, y};
        mag_x = x_neg ? (33'h1_0000_0000 - {1'b0, x}) : {1'b0, x};
        if (mag_x == 0 && mag_y == 0) begin
            val = 0;
        end else if (mag_x == 0) begin
            val = y_neg ? -HALF_PI_FIX : HALF_PI_FIX;
        end else if (!y_neg && mag_y != 0) begin
            if (mag_x > mag_y) val = table_angle(mag_y, mag_x);
            else               val = HALF_PI_FIX - table_angle(mag_x, mag_y);
            if (x_neg) val = PI_FIX - val;
        end else begin
            // y of zero lands here too
            if (mag_x > mag_y) val = -table_angle(mag_y, mag_x);
            else               val = -HALF_PI_FIX + table_angle(mag_x, mag_y);
            if (x_neg) val = -PI_FIX - val;
        end
        return val[ANGLE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_angle_rec rec;
        int         delta;
        if (!i_rst_n) begin
            fail_count <= 0;
            pending    <= 0;
            angle_q.delete();
        end else begin
            delta = 0;
            if (o_strobe) begin
                if (angle_q.size() == 0) begin
                    $display("%0t: unexpected angle beat: expected none, got %0d",
                             $time, o_angle);
                    fail_count <= fail_count + 1;
                end else begin
                    rec   = angle_q.pop_front();
                    delta = delta - 1;
                    if (o_angle !== rec.angle) begin
                        $display("%0t: angle mismatch for y=%0d x=%0d: expected %0d, got %0d",
                                 $time, rec.y, rec.x, rec.angle, o_angle);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                rec.y     = i_y_coord;
                rec.x     = i_x_coord;
                rec.angle = predict_angle(i_y_coord, i_x_coord);
                angle_q.push_back(rec);
                delta = delta + 1;
            end
            pending <= pending + delta;
        end
    end

endmodule

### verif/tb_atan2_octant_lut_unit.sv
// Testbench top for the atan2 unit: drives coordinate beats and reports the verdict.
module tb_atan2_octant_lut_unit;

    localparam int COORD_W      = atan2oct_pkg::COORD_W;
    localparam int ANGLE_W      = atan2oct_pkg::ANGLE_W;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 250;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start   = 1'b0;
    logic signed [COORD_W-1:0] y_coord = '0;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic                      busy;
    logic                      o_strobe;
    logic signed [ANGLE_W-1:0] o_angle;
    int                        fail_count;
    int                        pending;
    int                        cycle_count = 0;

    always #5 i_clk = ~i_clk;

    atan2_octant_lut_unit u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_y_coord (y_coord),
        .i_x_coord (x_coord),
        .o_strobe  (o_strobe),
        .o_angle   (o_angle)
    );

    atan2_angle_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_y_coord  (y_coord),
        .i_x_coord  (x_coord),
        .o_strobe   (o_strobe),
        .o_angle    (o_angle),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Idle at random, then hold the beat until the unit takes it.
    task automatic send_pair(input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] x,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        y_coord <= y;
        x_coord <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] extreme_coord();
        case ($urandom_range(5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return 0;
            3:       return 1;
            4:       return -1;
            default: return COORD_MIN + 1;
        endcase
    endfunction

    task automatic send_random(input int idle_pct);
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] swap;
        logic [31:0]               base;
        case ($urandom_range(9))
            0, 1: begin
                y = $urandom;
                x = $urandom;
            end
            2, 3: begin
                y = 32'($urandom_range(4096)) - 32'd2048;
                x = 32'($urandom_range(4096)) - 32'd2048;
            end
            4: begin
                // near the diagonal, where the table index tops out
                base = $urandom_range(32'h3FFF_FFFF);
                y    = base;
                x    = base + $urandom_range(64) - 32;
            end
            5: begin
                y = $urandom;
                x = 0;
            end
            6: begin
                y = extreme_coord();
                x = extreme_coord();
            end
            default: begin
                base = $urandom_range(32'h7FFF_FFFF, 32'h0010_0000);
                y    = base;
                x    = base >> $urandom_range(31);
            end
        endcase
        if ($urandom_range(1)) y = -y;
        if ($urandom_range(1)) x = -x;
        if ($urandom_range(1)) begin
            swap = y;
            y    = x;
            x    = swap;
        end
        send_pair(y, x, idle_pct);
    endtask

    initial begin
        int idle_pct;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pair(0, 0, 0);
        send_pair(5, 0, 0);
        send_pair(-5, 0, 0);
        send_pair(0, 5, 0);
        send_pair(0, -5, 0);
        send_pair(COORD_MIN, COORD_MIN, 0);
        send_pair(COORD_MAX, COORD_MAX, 0);
        send_pair(COORD_MIN, 0, 0);
        send_pair(0, COORD_MIN, 0);
        send_pair(COORD_MAX, COORD_MIN, 0);
        send_pair(COORD_MIN, COORD_MAX, 0);
        send_pair(1, 1, 0);
        send_pair(1, -1, 0);
        send_pair(-1, 1, 0);
        send_pair(-1, -1, 0);
        send_pair(3, 1000, 0);
        send_pair(1000, 3, 0);
        send_pair(-3, -1000, 0);
        send_pair(-1000, 3, 0);
        send_pair(COORD_MAX, 1, 0);
        send_pair(1, COORD_MAX, 0);
        send_pair(COORD_MIN, -1, 0);
        send_pair(-1, COORD_MIN, 0);
        send_pair(32'shAAAA_AAAA, 32'sh5555_5555, 0);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 12 : (phase == 1) ? 81 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random(idle_pct);
                if (phase == 0 && n == PHASE_ITEMS / 2) begin
                    // drain the pipeline before the next beat
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/atan2oct_pkg.sv
rtl/core/atan2_octant_lut_unit.sv
verif/atan2_angle_checker.sv
verif/tb_atan2_octant_lut_unit.sv
